// ===== rtl/rss_pkg.sv =====
package rss_pkg;

  // Item kinds.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SELECT = 1'b1;

  // Significant status and class words.
  localparam logic [15:0] STATUS_HIT  = 16'd3;
  localparam logic [15:0] STATUS_MIN  = 16'd1;
  localparam logic [15:0] CLASS_PREF  = 16'd1;

  // Running minimum start; only priorities strictly below it count.
  localparam logic signed [15:0] PRIO_START = -16'sd1;

  // Slot code returned when nothing qualifies.
  localparam logic [6:0] SLOT_NONE = 7'h7F;

  typedef enum logic [1:0] {
    SRC_HIT   = 2'd0,
    SRC_PREF  = 2'd1,
    SRC_OTHER = 2'd2,
    SRC_NONE  = 2'd3
  } src_t;

  typedef struct packed {
    logic               active;
    logic [15:0]        status;
    logic [15:0]        klass;
    logic signed [15:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPORT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;
    logic load;
    logic step;
    logic report;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;
  } sts_t;

endpackage

// ===== rtl/rss_controller.sv =====
module rss_controller
  import rss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic kind,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start && (kind == KIND_SELECT)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy       = 1'b0;
        cmd.write  = start && (kind == KIND_WRITE);
        cmd.load   = start && (kind == KIND_SELECT);
      end
      S_SCAN: begin
        cmd.step = 1'b1;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/rss_datapath.sv =====
module rss_datapath
  import rss_pkg::*;
#(
  parameter int SLOT_COUNT = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [5:0]         slot_index,
  input  logic               slot_active,
  input  logic [15:0]        slot_status,
  input  logic [15:0]        slot_class,
  input  logic signed [15:0] slot_priority,
  output sts_t               sts,
  output logic signed [6:0]  chosen_slot,
  output logic [1:0]         choice_source,
  output logic               done
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);
  localparam logic [8:0]       COUNT_W9 = 9'(SLOT_COUNT);

  entry_t                  mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]   valid;
  entry_t                  rd_data;
  logic                    rd_vbit;
  logic [IDX_W-1:0]        rd_idx;
  logic                    pipe_v;
  logic [IDX_W-1:0]        addr;
  logic [CNT_W-1:0]        issued;
  logic [IDX_W-1:0]        pointer;

  logic                    hit_found;
  logic [IDX_W-1:0]        hit_idx;
  logic                    pref_found;
  logic signed [15:0]      pref_min;
  logic [IDX_W-1:0]        pref_idx;
  logic                    other_found;
  logic signed [15:0]      other_min;
  logic [IDX_W-1:0]        other_idx;

  logic [8:0]              wide_index;
  logic                    wr_ok;
  logic [IDX_W-1:0]        wr_addr;
  logic [IDX_W-1:0]        port_addr;
  logic [IDX_W-1:0]        addr_next;
  entry_t                  wr_entry;
  entry_t                  cur;
  logic signed [15:0]      cur_prio;
  logic                    hit_now;
  logic                    min_now;
  logic                    pref_now;
  logic                    other_now;
  logic [8:0]              hit_w9;
  logic [8:0]              pref_w9;
  logic [8:0]              other_w9;

  assign wide_index = {3'b000, slot_index};
  assign wr_ok      = wide_index < COUNT_W9;
  assign wr_addr    = wide_index[IDX_W-1:0];
  assign port_addr  = cmd.write ? wr_addr : addr;
  assign addr_next  = (addr == LAST_IDX) ? '0 : addr + 1'b1;

  always_comb begin
    wr_entry.active = slot_active;
    wr_entry.status = slot_status;
    wr_entry.klass  = slot_class;
    wr_entry.prio   = slot_priority;
  end

  // Single-port table; entries never written read back as all zero.
  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      mem[port_addr] <= wr_entry;
    end
    rd_data <= mem[port_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      rd_vbit <= 1'b0;
    end else begin
      if (cmd.write && wr_ok) begin
        valid[port_addr] <= 1'b1;
      end
      rd_vbit <= valid[port_addr];
    end
  end

  assign cur      = rd_vbit ? rd_data : '0;
  assign cur_prio = cur.prio;

  assign hit_now   = pipe_v && cur.active && (cur.status == STATUS_HIT);
  assign min_now   = pipe_v && (cur.status == STATUS_MIN);
  assign pref_now  = min_now && (cur.klass == CLASS_PREF) && (cur_prio < pref_min);
  assign other_now = min_now && (cur.klass != CLASS_PREF) && (cur_prio < other_min);

  // The scan ends at a hit in the read being evaluated, or once the last
  // read has been evaluated: every slot was issued and its data sits in the read register.
  assign sts.scan_end = pipe_v && (hit_now || (issued == FULL_CNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      issued  <= '0;
      pipe_v  <= 1'b0;
      pointer <= '0;
    end else if (cmd.load) begin
      issued <= '0;
      pipe_v <= 1'b0;
    end else if (cmd.step) begin
      if (issued != FULL_CNT) begin
        issued <= issued + 1'b1;
        pipe_v <= 1'b1;
      end else begin
        pipe_v <= 1'b0;
      end
      if (hit_now) begin
        pointer <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr        <= pointer;
      hit_found   <= 1'b0;
      pref_found  <= 1'b0;
      other_found <= 1'b0;
      pref_min    <= PRIO_START;
      other_min   <= PRIO_START;
    end else if (cmd.step) begin
      if (issued != FULL_CNT) begin
        addr   <= addr_next;
        rd_idx <= addr;
      end
      if (hit_now) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
      end
      if (pref_now) begin
        pref_found <= 1'b1;
        pref_min   <= cur_prio;
        pref_idx   <= rd_idx;
      end
      if (other_now) begin
        other_found <= 1'b1;
        other_min   <= cur_prio;
        other_idx   <= rd_idx;
      end
    end
  end

  assign hit_w9   = 9'(hit_idx);
  assign pref_w9  = 9'(pref_idx);
  assign other_w9 = 9'(other_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      if (hit_found) begin
        chosen_slot   <= hit_w9[6:0];
        choice_source <= SRC_HIT;
      end else if (pref_found) begin
        chosen_slot   <= pref_w9[6:0];
        choice_source <= SRC_PREF;
      end else if (other_found) begin
        chosen_slot   <= other_w9[6:0];
        choice_source <= SRC_OTHER;
      end else begin
        chosen_slot   <= SLOT_NONE;
        choice_source <= SRC_NONE;
      end
    end
  end

endmodule

// ===== rtl/rotating_slot_selector.sv =====
// Slot table with a rotating selector. A write (kind 0) loads one slot and
// returns nothing; busy stays low. A select (kind 1) raises busy while the
// table, which sits in a single-port memory, is read one slot per cycle from
// the scan pointer onward, and while the result is reported; the scan ends
// early at the first active status-3 slot. The result appears on chosen_slot
// and choice_source with done high for one cycle, on the first cycle that
// busy is low again; there is no way to hold it, so the receiver must take
// it on that cycle. The table reads as all zero after reset with no clearing
// pass, and a new command may be started on the cycle done is high.
module rotating_slot_selector
  import rss_pkg::*;
#(
  parameter int SLOT_COUNT = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic [5:0]         slot_index,
  input  logic               slot_active,
  input  logic [15:0]        slot_status,
  input  logic [15:0]        slot_class,
  input  logic signed [15:0] slot_priority,
  output logic               done,
  output logic signed [6:0]  chosen_slot,
  output logic [1:0]         choice_source
);

  cmd_t cmd;
  sts_t sts;

  rss_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  rss_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .slot_index    (slot_index),
    .slot_active   (slot_active),
    .slot_status   (slot_status),
    .slot_class    (slot_class),
    .slot_priority (slot_priority),
    .sts           (sts),
    .chosen_slot   (chosen_slot),
    .choice_source (choice_source),
    .done          (done)
  );

endmodule

// ===== rtl/rss_checker.sv =====
module rss_assertions
  import rss_pkg::*;
#(
  parameter int SLOT_COUNT = 48
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              kind,
  input logic              done,
  input logic signed [6:0] chosen_slot,
  input logic [1:0]        choice_source
);

  // An accepted select makes the block busy on the next cycle.
  a_select_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (kind == KIND_SELECT) |=> busy)
    else $error("select transfer did not raise busy");

  // A write transfer never produces a result and never blocks.
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (kind == KIND_WRITE) |=> !busy && !done)
    else $error("write transfer produced a result or raised busy");

  // Results never come on consecutive cycles.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // No qualifying slot is reported as the all-ones code.
  a_none_code: assert property (@(posedge clk) disable iff (rst)
    done && (choice_source == SRC_NONE) |-> (chosen_slot == SLOT_NONE))
    else $error("empty selection without the none code");

  // A real selection never carries the none code while indexes fit.
  a_found_code: assert property (@(posedge clk) disable iff (rst)
    done && (choice_source != SRC_NONE) && (SLOT_COUNT <= 127)
      |-> (chosen_slot != SLOT_NONE))
    else $error("selection reported with the none code");

endmodule

bind rotating_slot_selector rss_assertions #(.SLOT_COUNT(SLOT_COUNT)) u_rss_checker (.*);
